[hw/rtl/owur_pkg.sv]
// ----------------------------------------------------------------------------
// owur_pkg
// shared types, codes and constants of the overwrite-oldest unit ring
// ----------------------------------------------------------------------------
package owur_pkg;

  localparam int unsigned SlotBytesDef = 512;
  localparam int unsigned SlotsDef     = 16;

  // function codes
  localparam logic [1:0] FuncPushStart = 2'd0;
  localparam logic [1:0] FuncPushData  = 2'd1;
  localparam logic [1:0] FuncPop       = 2'd2;
  localparam logic [1:0] FuncUnused    = 2'd3;

  // register indexes
  localparam logic RegSlotBytes = 1'b0;
  localparam logic RegSlots     = 1'b1;

  typedef enum logic [2:0] {
    StData      = 3'd0,
    StStarted   = 3'd1,
    StCommitted = 3'd2,
    StRejected  = 3'd3,
    StEmpty     = 3'd4,
    StDiscarded = 3'd5,
    StNoPush    = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] data_word;
    logic [15:0] unit_bytes;
    logic [63:0] timestamp_us;
    logic        key_frame;
    logic [15:0] reader_capacity;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] out_word;
    logic        last;
    logic [9:0]  out_unit_bytes;
    logic [63:0] out_timestamp_us;
    logic        out_key_frame;
    logic [63:0] sequence_number;
    logic [63:0] dropped_total;
    logic [4:0]  fill_level;
  } out_item_t;

  // job handed from front to back
  typedef enum logic [1:0] {
    JobStatus = 2'd0,
    JobWrite  = 2'd1,
    JobPop    = 2'd2
  } job_e;

  // head unit metadata travels with the job, taken when the item is accepted
  typedef struct packed {
    job_e        kind;
    logic [2:0]  status;
    logic        meta;
    logic [63:0] word;
    logic [7:0]  slot;
    logic [6:0]  pos;
    logic [9:0]  nwords;
    logic [63:0] drops;
    logic [8:0]  fill;
    logic [9:0]  msize;
    logic [63:0] mts;
    logic        mkey;
    logic [63:0] mseq;
  } job_t;

  typedef enum logic [1:0] {
    BkIdle = 2'd0,
    BkRead = 2'd1,
    BkMeta = 2'd2
  } back_state_e;

endpackage

[hw/rtl/owur_ram.sv]
// ----------------------------------------------------------------------------
// owur_ram
// generic single-port-write, single-read RAM with registered read
// ----------------------------------------------------------------------------
module owur_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[hw/rtl/owur_front.sv]
// ----------------------------------------------------------------------------
// owur_front
// accepts items, keeps ring bookkeeping and metadata, emits jobs
// ----------------------------------------------------------------------------
module owur_front #(
  parameter int unsigned SlotBytes = owur_pkg::SlotBytesDef,
  parameter int unsigned Slots     = owur_pkg::SlotsDef,
  localparam int unsigned Wps      = (SlotBytes + 7) / 8,
  localparam int unsigned SW       = (Slots > 1) ? $clog2(Slots) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  owur_pkg::in_item_t item_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  output logic               job_valid_o,
  output owur_pkg::job_t     job_o
);

  localparam int unsigned WW = $clog2(Wps + 1);

  logic [9:0]     sb_q, sb_d;
  logic [8:0]     ns_q, ns_d;
  logic [SW-1:0]  rd_q, rd_d, wr_q, wr_d;
  logic [8:0]     held_q, held_d;
  logic [63:0]    drop_q, drop_d, seq_q, seq_d;
  logic           open_q, open_d;
  logic [6:0]     pos_q, pos_d;
  logic           job_valid_q, job_valid_d;
  owur_pkg::job_t job_q, job_d;

  logic [9:0]  size_q  [Slots];
  logic [63:0] ts_q    [Slots];
  logic        key_q   [Slots];
  logic [63:0] sq_q    [Slots];

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

  logic [9:0]    cur_size;
  logic [WW-1:0] needed;
  logic [7:0]    pos_inc;
  logic [63:0]   masked;
  logic [9:0]    clamp_sb;
  logic [8:0]    clamp_ns;
  logic [SW-1:0] rd_inc, wr_inc;
  logic          meta_we, commit;

  // bookkeeping and job generation
  always_comb begin
    cur_size = size_q[wr_q];
    needed   = WW'((11'(cur_size) + 11'd7) >> 3);
    pos_inc  = 8'(pos_q) + 8'd1;
    masked   = item_i.data_word;
    if (pos_inc == 8'(needed) && cur_size[2:0] != 3'd0) begin
      masked = item_i.data_word & ((64'd1 << {cur_size[2:0], 3'b000}) - 64'd1);
    end
    rd_inc = (9'(rd_q) + 9'd1 >= ns_q) ? '0 : SW'(9'(rd_q) + 9'd1);
    wr_inc = (9'(wr_q) + 9'd1 >= ns_q) ? '0 : SW'(9'(wr_q) + 9'd1);
    clamp_sb = (cfg_data_i[9:0] == 10'd0) ? 10'd1 :
               (11'(cfg_data_i[9:0]) > 11'(SlotBytes)) ? 10'(SlotBytes) : cfg_data_i[9:0];
    clamp_ns = (cfg_data_i[4:0] == 5'd0) ? 9'd1 :
               (9'(cfg_data_i[4:0]) > 9'(Slots)) ? 9'(Slots) : 9'(cfg_data_i[4:0]);

    sb_d = sb_q; ns_d = ns_q; rd_d = rd_q; wr_d = wr_q; held_d = held_q;
    drop_d = drop_q; seq_d = seq_q; open_d = open_q; pos_d = pos_q;
    meta_we = 1'b0; commit = 1'b0;
    job_valid_d = 1'b0;
    job_d = job_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == owur_pkg::RegSlotBytes) begin
        sb_d = clamp_sb;
      end else begin
        ns_d = clamp_ns; rd_d = '0; wr_d = '0; held_d = '0;
        open_d = 1'b0; pos_d = '0;
      end
    end else if (take_i) begin
      job_valid_d   = 1'b1;
      job_d.kind    = owur_pkg::JobStatus;
      job_d.status  = owur_pkg::StData;
      job_d.meta    = 1'b0;
      job_d.word    = masked;
      job_d.slot    = 8'(rd_q);
      job_d.pos     = pos_q;
      job_d.nwords  = '0;
      job_d.msize   = size_q[rd_q];
      job_d.mts     = ts_q[rd_q];
      job_d.mkey    = key_q[rd_q];
      job_d.mseq    = sq_q[rd_q];
      unique case (item_i.func)
        owur_pkg::FuncPushStart: begin
          open_d = 1'b0; pos_d = '0;
          if (item_i.unit_bytes > 16'(sb_q)) begin
            job_d.status = owur_pkg::StRejected;
          end else begin
            if (held_q >= ns_q) begin
              rd_d = rd_inc; held_d = held_q - 9'd1; drop_d = drop_q + 64'd1;
            end
            meta_we = 1'b1;
            if (item_i.unit_bytes == 16'd0) begin
              commit = 1'b1;
              job_d.status = owur_pkg::StCommitted;
            end else begin
              open_d = 1'b1;
              job_d.status = owur_pkg::StStarted;
            end
          end
        end
        owur_pkg::FuncPushData: begin
          if (!open_q) begin
            job_d.status = owur_pkg::StNoPush;
          end else begin
            job_d.kind = owur_pkg::JobWrite;
            job_d.slot = 8'(wr_q);
            pos_d = pos_inc[6:0];
            if (pos_inc >= 8'(needed)) begin
              commit = 1'b1;
              job_d.status = owur_pkg::StCommitted;
            end else begin
              job_d.status = owur_pkg::StData;
            end
          end
        end
        owur_pkg::FuncPop: begin
          if (held_q == 9'd0) begin
            job_d.status = owur_pkg::StEmpty;
          end else begin
            rd_d = rd_inc; held_d = held_q - 9'd1;
            job_d.meta = 1'b1;
            if (16'(size_q[rd_q]) > item_i.reader_capacity) begin
              job_d.status = owur_pkg::StDiscarded;
            end else begin
              job_d.status = owur_pkg::StData;
              job_d.kind   = owur_pkg::JobPop;
              job_d.nwords = 10'((11'(size_q[rd_q]) + 11'd7) >> 3);
            end
          end
        end
        default: begin
          job_valid_d = 1'b0;
        end
      endcase
      if (commit) begin
        seq_d = seq_q + 64'd1;
        wr_d = wr_inc; held_d = held_d + 9'd1;
        open_d = 1'b0; pos_d = '0;
      end
      job_d.drops = drop_d; job_d.fill = held_d;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_q <= 10'(SlotBytes); ns_q <= 9'(Slots);
      rd_q <= '0; wr_q <= '0; held_q <= '0;
      drop_q <= '0; seq_q <= '0; open_q <= 1'b0; pos_q <= '0;
      job_valid_q <= 1'b0;
    end else begin
      sb_q <= sb_d; ns_q <= ns_d;
      rd_q <= rd_d; wr_q <= wr_d; held_q <= held_d;
      drop_q <= drop_d; seq_q <= seq_d; open_q <= open_d; pos_q <= pos_d;
      job_valid_q <= job_valid_d;
    end
  end

  // job register and slot metadata
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (meta_we) begin
      size_q[wr_q] <= item_i.unit_bytes[9:0];
      ts_q[wr_q]   <= item_i.timestamp_us;
      key_q[wr_q]  <= item_i.key_frame;
    end
    if (commit) begin
      sq_q[wr_q] <= seq_q;
    end
  end

endmodule

[hw/rtl/owur_back.sv]
// ----------------------------------------------------------------------------
// owur_back
// pulls jobs from the queue, writes and streams slot words, drives results
// ----------------------------------------------------------------------------
module owur_back #(
  parameter int unsigned SlotBytes = owur_pkg::SlotBytesDef,
  parameter int unsigned Slots     = owur_pkg::SlotsDef,
  localparam int unsigned Wps      = (SlotBytes + 7) / 8,
  localparam int unsigned SW       = (Slots > 1) ? $clog2(Slots) : 1,
  localparam int unsigned Depth    = Slots * Wps,
  localparam int unsigned AW       = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  owur_pkg::job_t      job_i,
  output logic                job_pop_o,
  output logic                res_valid_o,
  output owur_pkg::out_item_t res_o
);

  owur_pkg::back_state_e state_q, state_d;
  logic [9:0] idx_q, idx_d;
  logic       we, re;
  logic [AW-1:0] waddr, raddr;
  logic [63:0] rdata;

  owur_ram #(.Width(64), .Depth(Depth)) u_words (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(job_i.word),
    .re_i(re), .raddr_i(raddr), .rdata_o(rdata)
  );

  // read stage control
  logic       rd_vld_q;
  logic       rd_last_q;

  always_comb begin
    state_d = state_q; idx_d = idx_q; job_pop_o = 1'b0;
    we = 1'b0; re = 1'b0;
    waddr = AW'(32'(SW'(job_i.slot)) * Wps + 32'(job_i.pos));
    raddr = AW'(32'(SW'(job_i.slot)) * Wps + 32'(idx_q));
    unique case (state_q)
      owur_pkg::BkIdle: begin
        if (job_valid_i) begin
          if (job_i.kind == owur_pkg::JobPop && job_i.nwords != 10'd0) begin
            state_d = owur_pkg::BkRead; idx_d = '0;
          end else begin
            we = (job_i.kind == owur_pkg::JobWrite) && (32'(job_i.pos) < Wps);
            job_pop_o = 1'b1;
          end
        end
      end
      owur_pkg::BkRead: begin
        re = 1'b1; idx_d = idx_q + 10'd1;
        if (idx_q + 10'd1 == job_i.nwords) begin
          state_d = owur_pkg::BkIdle; job_pop_o = 1'b1;
        end
      end
      default: state_d = owur_pkg::BkIdle;
    endcase
  end

  // result strobe lines up with the registered word read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= owur_pkg::BkIdle; idx_q <= '0; rd_vld_q <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      state_q <= state_d; idx_q <= idx_d;
      rd_vld_q <= re;
      res_valid_o <= re || (state_q == owur_pkg::BkIdle && job_pop_o);
    end
  end

  // metadata staging for the read stage and result formatting
  owur_pkg::out_item_t hold_q;
  always_ff @(posedge clk_i) begin
    rd_last_q <= re && (idx_q + 10'd1 == job_i.nwords);
    hold_q.status           <= job_i.status;
    hold_q.out_word         <= '0;
    hold_q.last             <= 1'b1;
    hold_q.out_unit_bytes   <= job_i.meta ? job_i.msize : '0;
    hold_q.out_timestamp_us <= job_i.meta ? job_i.mts : '0;
    hold_q.out_key_frame    <= job_i.meta ? job_i.mkey : 1'b0;
    hold_q.sequence_number  <= job_i.meta ? job_i.mseq : '0;
    hold_q.dropped_total    <= job_i.drops;
    hold_q.fill_level       <= job_i.fill[4:0];
  end

  always_comb begin
    res_o = hold_q;
    if (rd_vld_q) begin
      res_o.out_word = rdata;
      res_o.last     = rd_last_q;
    end
  end

endmodule

[hw/rtl/owur_queue.sv]
// ----------------------------------------------------------------------------
// owur_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module owur_queue #(
  parameter int unsigned Entries = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  owur_pkg::job_t data_i,
  input  logic           pop_i,
  output logic           valid_o,
  output owur_pkg::job_t data_o,
  output logic           full_o
);

  localparam int unsigned PW = $clog2(Entries);
  owur_pkg::job_t buf_q [Entries];
  logic [PW-1:0] rp_q, wp_q;
  logic [PW:0]   cnt_q;

  // one entry stays free for the job the front still holds in flight
  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q >= (PW+1)'(Entries - 1);
  assign data_o  = buf_q[rp_q];

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= '0; wp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (32'(wp_q) == Entries - 1) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (32'(rp_q) == Entries - 1) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wp_q] <= data_i;
  end

endmodule

[hw/rtl/overwrite_oldest_unit_ring.sv]
// ----------------------------------------------------------------------------
// overwrite_oldest_unit_ring
// ring of media unit slots that drops the oldest unit when full
// ----------------------------------------------------------------------------
// Usage: drive an item on item_i with start high; it transfers at a rising
// edge with busy low. Push start, push data, a pop of an empty ring and a
// discarding pop give one result; a pop streams one result per unit word,
// last set in res_o on the final word, or one result for a zero-size unit.
// Results appear on res_o with res_valid_o for one cycle each; the receiver
// cannot stall. With the back end idle, a result passes the job register,
// job queue and result register; a streaming pop adds a start step and the
// RAM read. The front takes one item per cycle; a pop of N words holds the
// back end for a start step and N word RAM reads, while the front keeps
// taking items until the four-entry job queue holds three jobs and busy
// rises. Configuration is written through cfg_valid_i/cfg_ready_o while
// idle; a write of the slot count empties the ring. Reset empties the ring
// and clears counters; slot contents are undefined until written.
// ----------------------------------------------------------------------------
module overwrite_oldest_unit_ring #(
  parameter int unsigned SlotBytes = owur_pkg::SlotBytesDef,
  parameter int unsigned Slots     = owur_pkg::SlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  owur_pkg::in_item_t  item_i,
  output logic                res_valid_o,
  output owur_pkg::out_item_t res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  logic           jv, qv, qfull, qpop;
  owur_pkg::job_t job, qjob;

  assign busy        = qfull;
  assign cfg_ready_o = 1'b1;

  owur_front #(.SlotBytes(SlotBytes), .Slots(Slots)) u_front (
    .clk_i, .rst_ni, .take_i(start && !busy), .item_i,
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i,
    .job_valid_o(jv), .job_o(job)
  );

  owur_queue #(.Entries(4)) u_queue (
    .clk_i, .rst_ni, .push_i(jv), .data_i(job), .pop_i(qpop),
    .valid_o(qv), .data_o(qjob), .full_o(qfull)
  );

  owur_back #(.SlotBytes(SlotBytes), .Slots(Slots)) u_back (
    .clk_i, .rst_ni, .job_valid_i(qv), .job_i(qjob), .job_pop_o(qpop),
    .res_valid_o, .res_o
  );

`ifndef SYNTH
  // queue never pops when empty
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni) qpop |-> qv)
    else $error("job popped from empty queue");
  // a job only follows an accept made while the queue had room
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jv |-> !$past(qfull))
    else $error("job pushed into full queue");
`endif

endmodule

[tb/tb_overwrite_oldest_unit_ring.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_overwrite_oldest_unit_ring
// regression of the overwrite-oldest media unit ring: directed corner items
// and random push/pop traffic, checked against an in-bench ring predictor
// ----------------------------------------------------------------------------
module tb_overwrite_oldest_unit_ring;

  localparam int unsigned WordsPerSlot = (owur_pkg::SlotBytesDef + 7) / 8;
  localparam int unsigned CycleLimit   = 400000;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  owur_pkg::in_item_t  item_i;
  logic                res_valid_o;
  owur_pkg::out_item_t res_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic                cfg_index_i;
  logic [15:0]         cfg_data_i;

  overwrite_oldest_unit_ring dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // predictor state
  logic [63:0] ring_words [owur_pkg::SlotsDef * WordsPerSlot];
  logic [9:0]  ring_size  [owur_pkg::SlotsDef];
  logic [63:0] ring_stamp [owur_pkg::SlotsDef];
  logic        ring_key   [owur_pkg::SlotsDef];
  logic [63:0] ring_seq   [owur_pkg::SlotsDef];
  int unsigned rd_slot, wr_slot, units_held, word_pos;
  logic [63:0] drop_count, seq_next;
  logic        push_active;
  int unsigned slot_bytes_cfg, slot_count_cfg;

  owur_pkg::out_item_t expected_results [$];
  int          fail_count;
  int unsigned item_count, result_count, cycle_count;
  int unsigned pushes_done, pops_done;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("cycle limit reached");
        $display("overwrite_oldest_unit_ring regression: fail");
        $finish;
      end
    end
  end

  function automatic int unsigned clamp_cfg(int unsigned v, int unsigned top);
    if (v < 1) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic owur_pkg::out_item_t ring_result(logic [2:0] st, logic [63:0] w,
                                                      logic lst, int slot);
    owur_pkg::out_item_t r;
    r = '0;
    r.status = st;
    r.out_word = w;
    r.last = lst;
    if (slot >= 0) begin
      r.out_unit_bytes   = ring_size[slot];
      r.out_timestamp_us = ring_stamp[slot];
      r.out_key_frame    = ring_key[slot];
      r.sequence_number  = ring_seq[slot];
    end
    r.dropped_total = drop_count;
    r.fill_level    = units_held[4:0];
    return r;
  endfunction

  function automatic void commit_unit();
    ring_seq[wr_slot] = seq_next;
    seq_next++;
    wr_slot = (wr_slot + 1) % slot_count_cfg;
    units_held++;
    push_active = 1'b0;
    word_pos = 0;
  endfunction

  // expected results of one accepted item
  function automatic void predict_ring(owur_pkg::in_item_t it);
    int unsigned sz, need, rem, head, nw;
    logic [63:0] w;
    case (it.func)
      owur_pkg::FuncPushStart: begin
        sz = it.unit_bytes;
        push_active = 1'b0;
        word_pos = 0;
        if (sz > slot_bytes_cfg) begin
          expected_results.push_back(ring_result(owur_pkg::StRejected, '0, 1'b1, -1));
        end else begin
          if (units_held >= slot_count_cfg) begin
            rd_slot = (rd_slot + 1) % slot_count_cfg;
            units_held--;
            drop_count++;
          end
          ring_size[wr_slot]  = sz[9:0];
          ring_stamp[wr_slot] = it.timestamp_us;
          ring_key[wr_slot]   = it.key_frame;
          if (sz == 0) begin
            commit_unit();
            expected_results.push_back(ring_result(owur_pkg::StCommitted, '0, 1'b1, -1));
          end else begin
            push_active = 1'b1;
            expected_results.push_back(ring_result(owur_pkg::StStarted, '0, 1'b1, -1));
          end
        end
      end
      owur_pkg::FuncPushData: begin
        if (!push_active) begin
          expected_results.push_back(ring_result(owur_pkg::StNoPush, '0, 1'b1, -1));
        end else begin
          sz = ring_size[wr_slot];
          need = (sz + 7) / 8;
          rem = sz % 8;
          w = it.data_word;
          if (word_pos + 1 == need && rem != 0) w &= (64'd1 << (8 * rem)) - 64'd1;
          if (word_pos < WordsPerSlot) ring_words[wr_slot * WordsPerSlot + word_pos] = w;
          word_pos++;
          if (word_pos >= need) begin
            commit_unit();
            expected_results.push_back(ring_result(owur_pkg::StCommitted, '0, 1'b1, -1));
          end else begin
            expected_results.push_back(ring_result(owur_pkg::StData, '0, 1'b1, -1));
          end
        end
      end
      owur_pkg::FuncPop: begin
        if (units_held == 0) begin
          expected_results.push_back(ring_result(owur_pkg::StEmpty, '0, 1'b1, -1));
        end else begin
          head = rd_slot;
          sz = ring_size[head];
          rd_slot = (rd_slot + 1) % slot_count_cfg;
          units_held--;
          if (sz > it.reader_capacity) begin
            expected_results.push_back(ring_result(owur_pkg::StDiscarded, '0, 1'b1, head));
          end else begin
            nw = (sz + 7) / 8;
            if (nw == 0) begin
              expected_results.push_back(ring_result(owur_pkg::StData, '0, 1'b1, head));
            end else begin
              for (int i = 0; i < nw; i++)
                expected_results.push_back(ring_result(owur_pkg::StData,
                  ring_words[head * WordsPerSlot + i], (i + 1 == nw), head));
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // result checker
  initial begin
    owur_pkg::out_item_t exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_valid_o) begin
        result_count++;
        if (expected_results.size() == 0) begin
          $error("unexpected result, status %0d", res_o.status);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (res_o.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, res_o.status); fail_count++;
          end
          if (res_o.out_word !== exp_r.out_word) begin
            $error("out_word exp %h got %h", exp_r.out_word, res_o.out_word); fail_count++;
          end
          if (res_o.last !== exp_r.last) begin
            $error("last exp %0d got %0d", exp_r.last, res_o.last); fail_count++;
          end
          if (res_o.out_unit_bytes !== exp_r.out_unit_bytes) begin
            $error("out_unit_bytes exp %0d got %0d", exp_r.out_unit_bytes,
                   res_o.out_unit_bytes); fail_count++;
          end
          if (res_o.out_timestamp_us !== exp_r.out_timestamp_us) begin
            $error("out_timestamp_us exp %h got %h", exp_r.out_timestamp_us,
                   res_o.out_timestamp_us); fail_count++;
          end
          if (res_o.out_key_frame !== exp_r.out_key_frame) begin
            $error("out_key_frame exp %0d got %0d", exp_r.out_key_frame,
                   res_o.out_key_frame); fail_count++;
          end
          if (res_o.sequence_number !== exp_r.sequence_number) begin
            $error("sequence_number exp %0d got %0d", exp_r.sequence_number,
                   res_o.sequence_number); fail_count++;
          end
          if (res_o.dropped_total !== exp_r.dropped_total) begin
            $error("dropped_total exp %0d got %0d", exp_r.dropped_total,
                   res_o.dropped_total); fail_count++;
          end
          if (res_o.fill_level !== exp_r.fill_level) begin
            $error("fill_level exp %0d got %0d", exp_r.fill_level, res_o.fill_level);
            fail_count++;
          end
        end
      end
    end
  end

  // one item transfer, with a random gap in front; start stays high after
  // the accepting edge until the next falling edge drives the next item or idle
  task automatic send_item(owur_pkg::in_item_t it);
    int unsigned gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk_i);
    if (gap != 0) begin
      start  <= 1'b0;
      item_i <= '0;
      repeat (gap) @(negedge clk_i);
    end
    item_i <= it;
    start  <= 1'b1;
    do @(posedge clk_i); while (busy);
    predict_ring(it);
    item_count++;
  endtask

  function automatic owur_pkg::in_item_t rand_fields();
    owur_pkg::in_item_t it;
    it.func            = owur_pkg::FuncPushStart;
    it.data_word       = {$urandom, $urandom};
    it.unit_bytes      = 16'($urandom);
    it.timestamp_us    = {$urandom, $urandom};
    it.key_frame       = 1'($urandom);
    it.reader_capacity = 16'($urandom);
    return it;
  endfunction

  task automatic push_start(int unsigned nbytes);
    owur_pkg::in_item_t it;
    it = rand_fields();
    it.unit_bytes = 16'(nbytes);
    send_item(it);
  endtask

  task automatic push_data(logic [63:0] w);
    owur_pkg::in_item_t it;
    it = rand_fields();
    it.func = owur_pkg::FuncPushData;
    it.data_word = w;
    send_item(it);
  endtask

  task automatic pop_unit(int unsigned cap);
    owur_pkg::in_item_t it;
    it = rand_fields();
    it.func = owur_pkg::FuncPop;
    it.reader_capacity = 16'(cap);
    send_item(it);
    pops_done++;
  endtask

  // full push of one unit with random words
  task automatic push_unit(int unsigned nbytes);
    push_start(nbytes);
    for (int i = 0; i < (nbytes + 7) / 8; i++) push_data({$urandom, $urandom});
    pushes_done++;
  endtask

  // drop start, drain results, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk_i);
    start  <= 1'b0;
    item_i <= '0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == owur_pkg::RegSlotBytes) begin
      slot_bytes_cfg = clamp_cfg(val[9:0], owur_pkg::SlotBytesDef);
    end else begin
      slot_count_cfg = clamp_cfg(val[4:0], owur_pkg::SlotsDef);
      rd_slot = 0; wr_slot = 0; units_held = 0;
      push_active = 1'b0; word_pos = 0;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // directed corners: extremes, every operation and status
  task automatic test_directed();
    owur_pkg::in_item_t it;
    pop_unit(16'hFFFF);                     // empty ring
    push_data(64'hFFFF_FFFF_FFFF_FFFF);     // data without open push
    push_start(0);                          // zero-size unit commits at once
    pop_unit(0);                            // zero-size pop
    push_start(513);                        // too large for the slot
    push_start(16'hFFFF);
    push_start(12);                         // abandoned by the next start
    push_start(13);                         // partial final word is masked
    push_data(64'hFFFF_FFFF_FFFF_FFFF);
    push_data(64'hFFFF_FFFF_FFFF_FFFF);
    pop_unit(12);                           // discarded, reader too small
    push_unit(512);                         // largest unit
    pop_unit(16'hFFFF);
    it = rand_fields();
    it.func = owur_pkg::FuncUnused;         // unused function, no result
    send_item(it);
    push_unit(8);
    pop_unit(8);
  endtask

  // overwrite with a short ring and tiny slots
  task automatic test_overwrite();
    wait_idle();
    write_reg(owur_pkg::RegSlots, 16'd0);       // acts as one slot
    write_reg(owur_pkg::RegSlotBytes, 16'd0);   // acts as one byte
    push_unit(1);
    push_start(1);                          // full: drops oldest
    push_start(2);                          // rejected
    push_data(64'h0123_4567_89AB_CDEF);
    pop_unit(1);
    wait_idle();
    write_reg(owur_pkg::RegSlots, 16'd3);
    write_reg(owur_pkg::RegSlotBytes, 16'd24);
    for (int i = 0; i < 5; i++) push_unit($urandom_range(0, 24));
    pop_unit(16'hFFFF);
    pop_unit(16'hFFFF);
  endtask

  // random traffic, mostly well-formed pushes and pops
  task automatic test_random(int unsigned n_items);
    int unsigned sel, nb;
    while (item_count < n_items) begin
      sel = $urandom_range(0, 9);
      nb  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, slot_bytes_cfg)
                                         : $urandom_range(0, 40);
      if (sel < 5) push_unit(nb);
      else if (sel < 8) pop_unit(($urandom_range(0, 5) == 0) ? $urandom_range(0, 40)
                                                              : 16'hFFFF);
      else if (sel == 8) push_start(nb);
      else push_data({$urandom, $urandom});
    end
  endtask

  initial begin
    fail_count = 0; item_count = 0; result_count = 0;
    pushes_done = 0; pops_done = 0;
    rd_slot = 0; wr_slot = 0; units_held = 0; word_pos = 0;
    drop_count = '0; seq_next = '0; push_active = 1'b0;
    slot_bytes_cfg = owur_pkg::SlotBytesDef; slot_count_cfg = owur_pkg::SlotsDef;
    start = 1'b0; item_i = '0;
    cfg_valid_i = 1'b0; cfg_index_i = owur_pkg::RegSlotBytes; cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_directed();
    test_overwrite();
    wait_idle();
    write_reg(owur_pkg::RegSlots, 16'd31);        // above range, acts as 16
    write_reg(owur_pkg::RegSlotBytes, 16'd1023);  // above range, acts as 512
    test_random(item_count + 12);
    wait_idle();
    write_reg(owur_pkg::RegSlots, 16'd2);
    write_reg(owur_pkg::RegSlotBytes, 16'd40);
    test_random(item_count + 8);
    wait_idle();

    $display("covered %0d items, %0d results, %0d full pushes, %0d pops, %0d drops",
             item_count, result_count, pushes_done, pops_done, drop_count);
    if (fail_count == 0) begin
      $display("overwrite_oldest_unit_ring regression: pass");
    end else begin
      $display("overwrite_oldest_unit_ring regression: fail");
    end
    $finish;
  end

endmodule
